[hdl/bms_pkg.sv]
// Package: shared constants, codes and types of the buzzer melody sequencer.
package bms_pkg;

  // Default note table depth
  localparam int unsigned NOTES_DEF = 256;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned TEMPO_W = 8;
  localparam int unsigned MS_W    = 20;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned CD_W    = 19;
  localparam int unsigned BPM_W   = 10;
  localparam int unsigned REF_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Divider widths: dividend up to 60000*15, divisor up to 255*1023
  localparam int unsigned DVD_W = 20;
  localparam int unsigned DVS_W = 18;
  localparam int unsigned CNT_W = 5;

  // Countdown reload: floor(dur*22/100) as (dur*22 * RECIP) >> RECIP_SH
  localparam int unsigned SCL_W    = 25;
  localparam int unsigned RECIP_SH = 32;
  localparam int unsigned PROD_W   = 51;
  localparam logic [25:0] RECIP    = 26'd42949673;

  // Duration numerators
  localparam logic [15:0] BPM_NUM  = 16'd60000;
  localparam logic [9:0]  OLD_NUM  = 10'd1000;

  // Most negative countdown value
  localparam logic signed [CD_W-1:0] CD_MIN = {1'b1, {(CD_W-1){1'b0}}};

  // Item opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPO_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPM_SCALED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_REF   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEL_LEN    = 2'd3;

  // Configuration reset values
  localparam logic [BPM_W-1:0] BPM_RST = 10'd230;
  localparam logic [REF_W-1:0] REF_RST = 4'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_SCALE,
    S_MUL,
    S_FIN,
    S_EMIT
  } state_e;

endpackage

[hdl/buzzer_melody_sequencer.sv]
// Top level: buzzer melody sequencer with note table memory and serial divider.

// Items enter one at a time. A load, a start, or a tick that begins no note goes
// from idle to the emit state, which loads its result into the output register
// and returns to idle, where the next item is taken. A tick that begins a note
// goes through one memory read of the note entry, 20 steps of the one-bit-per-
// cycle restoring divider that yields the duration, then the countdown reload
// (scale, reciprocal multiply, update) and the output load. A zero divisor skips
// the divider. A finished result waits in the output register while the next
// item is taken; if it still waits when the next result is ready, that item is
// held in the emit state until the output register is free. The note table is a
// 1W1R memory of NOTES entries with no reset: play only entries that were loaded.
module buzzer_melody_sequencer
  import bms_pkg::*;
#(
  parameter int unsigned NOTES = NOTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [IDX_W-1:0]      note_index_i,
  input  logic [FREQ_W-1:0]     note_freq_i,
  input  logic [TEMPO_W-1:0]    note_tempo_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  tone_start_o,
  output logic                  tone_stop_o,
  output logic [FREQ_W-1:0]     tone_freq_o,
  output logic [MS_W-1:0]       tone_ms_o,
  output logic                  playing_o,
  output logic                  div_error_o
);

  localparam int unsigned AW    = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int unsigned ENT_W = FREQ_W + TEMPO_W;

  state_e state_q, state_d;

  // configuration registers
  logic             tempo_mode_q;
  logic [BPM_W-1:0] bpm_q;
  logic [REF_W-1:0] ref_q;
  logic [POS_W-1:0] len_q;

  // player state
  logic [POS_W-1:0]        pos_q;
  logic signed [CD_W-1:0]  cd_q;
  logic                    active_q;

  // note fetch and arithmetic
  logic [ENT_W-1:0]   rd_q;
  logic               inrange_q;
  logic [FREQ_W-1:0]  f_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [DVD_W-1:0]   quo_q;
  logic [DVS_W-1:0]   rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SCL_W-1:0]   x_q;
  logic [PROD_W-1:0]  prod_q;
  logic               err_q;

  // pending result
  logic              res_start_q, res_stop_q, res_err_q;
  logic [FREQ_W-1:0] res_freq_q;
  logic [MS_W-1:0]   res_ms_q;

  // output register
  logic              out_valid_q;
  logic              o_start_q, o_stop_q, o_play_q, o_err_q;
  logic [FREQ_W-1:0] o_freq_q;
  logic [MS_W-1:0]   o_ms_q;

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------------
  // Item decode
  logic [31:0]            idx_ext, pos_ext;
  logic [AW-1:0]          waddr, raddr;
  logic                   idx_ok, pos_ok;
  logic signed [CD_W-1:0] cd_dec;
  logic                   cd_due, is_tick, at_end;

  assign idx_ext = 32'(note_index_i);
  assign pos_ext = 32'(pos_q);
  assign waddr   = idx_ext[AW-1:0];
  assign raddr   = pos_ext[AW-1:0];
  assign idx_ok  = idx_ext < NOTES;
  assign pos_ok  = pos_ext < NOTES;
  assign cd_dec  = (cd_q == CD_MIN) ? cd_q : cd_q - CD_W'(1);
  assign cd_due  = cd_dec[CD_W-1] || (cd_dec == '0);
  assign is_tick = (opcode_i == OP_TICK) && active_q;
  assign at_end  = pos_q >= len_q;

  // ---------------------------------------------------------------------------
  // Note table memory
  logic [ENT_W-1:0] mem [NOTES];
  logic mem_we, mem_re;
  assign mem_we = in_acc && (opcode_i == OP_LOAD) && idx_ok;
  assign mem_re = in_acc && is_tick && !at_end && cd_due;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= {note_freq_i, note_tempo_i};
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Operand selection from the fetched entry
  logic [FREQ_W-1:0]  ent_f;
  logic [TEMPO_W-1:0] ent_t;
  logic [DVS_W-1:0]   dvs_sel;
  logic [DVD_W-1:0]   dvd_sel;

  assign ent_f = inrange_q ? rd_q[ENT_W-1:TEMPO_W] : '0;
  assign ent_t = inrange_q ? rd_q[TEMPO_W-1:0] : '0;

  always_comb begin
    if (tempo_mode_q) begin
      dvs_sel = DVS_W'(ent_t) * DVS_W'(bpm_q);
      dvd_sel = DVD_W'(BPM_NUM) * DVD_W'(ref_q);
    end else begin
      dvs_sel = DVS_W'(ent_t);
      dvd_sel = DVD_W'(OLD_NUM);
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider step
  logic [DVS_W:0] div_sh, div_diff;
  logic           div_ge;

  assign div_sh   = {rem_q, quo_q[DVD_W-1]};
  assign div_ge   = div_sh >= {1'b0, dvs_q};
  assign div_diff = div_sh - {1'b0, dvs_q};

  logic [SCL_W-1:0] q_ext;
  assign q_ext = SCL_W'(quo_q);

  // ---------------------------------------------------------------------------
  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = mem_re ? S_READ : S_EMIT;
        end
      end
      S_READ:  state_d = (dvs_sel == '0) ? S_SCALE : S_DIV;
      S_DIV:   state_d = (cnt_q == CNT_W'(DVD_W - 1)) ? S_SCALE : S_DIV;
      S_SCALE: state_d = S_MUL;
      S_MUL:   state_d = S_FIN;
      S_FIN:   state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_mode_q <= 1'b0;
      bpm_q        <= BPM_RST;
      ref_q        <= REF_RST;
      len_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMPO_MODE: tempo_mode_q <= cfg_data_i[0];
        CFG_BPM_SCALED: bpm_q        <= cfg_data_i[BPM_W-1:0];
        CFG_BEAT_REF:   ref_q        <= cfg_data_i[REF_W-1:0];
        CFG_MEL_LEN:    len_q        <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Player state: position, countdown, active
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cd_q     <= '0;
      active_q <= 1'b0;
    end else if (state_q == S_IDLE && in_acc) begin
      if (opcode_i == OP_START) begin
        pos_q    <= '0;
        cd_q     <= '0;
        active_q <= 1'b1;
      end else if (is_tick) begin
        if (at_end) begin
          active_q <= 1'b0;
        end else begin
          cd_q <= cd_dec;
        end
      end
    end else if (state_q == S_FIN) begin
      // reload countdown and advance to the next note
      cd_q  <= signed'(prod_q[PROD_W-1:RECIP_SH]);
      pos_q <= pos_q + POS_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Duration datapath and pending result
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        inrange_q   <= pos_ok;
        res_start_q <= 1'b0;
        res_stop_q  <= in_acc && is_tick && at_end;
        res_freq_q  <= '0;
        res_ms_q    <= '0;
        res_err_q   <= 1'b0;
      end
      S_READ: begin
        f_q   <= ent_f;
        dvs_q <= dvs_sel;
        rem_q <= '0;
        cnt_q <= '0;
        err_q <= (dvs_sel == '0);
        quo_q <= (dvs_sel == '0) ? '0 : dvd_sel;
      end
      S_DIV: begin
        // shift one quotient bit in per cycle
        quo_q <= {quo_q[DVD_W-2:0], div_ge};
        rem_q <= div_ge ? div_diff[DVS_W-1:0] : div_sh[DVS_W-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
      end
      S_SCALE: x_q    <= (q_ext << 4) + (q_ext << 2) + (q_ext << 1);
      S_MUL:   prod_q <= PROD_W'(x_q) * PROD_W'(RECIP);
      S_FIN: begin
        res_start_q <= 1'b1;
        res_freq_q  <= f_q;
        res_ms_q    <= quo_q;
        res_err_q   <= err_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: load from the pending result, drop on handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      o_start_q <= res_start_q;
      o_stop_q  <= res_stop_q;
      o_freq_q  <= res_freq_q;
      o_ms_q    <= res_ms_q;
      o_play_q  <= active_q;
      o_err_q   <= res_err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tone_start_o = o_start_q;
  assign tone_stop_o  = o_stop_q;
  assign tone_freq_o  = o_freq_q;
  assign tone_ms_o    = o_ms_q;
  assign playing_o    = o_play_q;
  assign div_error_o  = o_err_q;

endmodule

[bench/tb.sv]
// Testbench for the buzzer melody sequencer: directed script, random melodies, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bms_pkg::*;

  // Unused opcode: the block must leave its state alone
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  // Countdown reload is floor(duration * 22 / 100) ticks
  localparam int unsigned RELOAD_NUM = 22;
  localparam int unsigned RELOAD_DEN = 100;
  localparam int CD_FLOOR = -int'(2 ** (CD_W - 1));
  // Idle tail that settle() waits once every tone is back
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_ITEMS  = 1500;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [IDX_W-1:0]   idx;
    logic [FREQ_W-1:0]  freq;
    logic [TEMPO_W-1:0] tempo;
  } note_item_t;

  typedef struct packed {
    logic              start;
    logic              stop;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
    logic              playing;
    logic              err;
  } tone_res_t;

  // One script row: a register write or a beat, with an optional hand-typed result
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    note_item_t            beat;
    bit                    typed;
    tone_res_t             tone;
  } script_row_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [OP_W-1:0]       opcode_i     = '0;
  logic [IDX_W-1:0]      note_index_i = '0;
  logic [FREQ_W-1:0]     note_freq_i  = '0;
  logic [TEMPO_W-1:0]    note_tempo_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  tone_start_o;
  logic                  tone_stop_o;
  logic [FREQ_W-1:0]     tone_freq_o;
  logic [MS_W-1:0]       tone_ms_o;
  logic                  playing_o;
  logic                  div_error_o;

  // Player mirror: note table, position, countdown, run flag and registers
  logic [FREQ_W-1:0]  note_freq_tab  [NOTES_DEF];
  logic [TEMPO_W-1:0] note_tempo_tab [NOTES_DEF];
  logic [POS_W-1:0]   play_pos  = '0;
  int                 ticks_left = 0;
  bit                 player_on = 1'b0;
  bit                 bpm_mode  = 1'b0;
  logic [BPM_W-1:0]   bpm_cfg   = BPM_RST;
  logic [REF_W-1:0]   beat_ref  = REF_RST;
  logic [POS_W-1:0]   song_len  = '0;

  tone_res_t   tones_due[$];
  script_row_t script[$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatches     = 0;
  int items_sent     = 0;
  int busy_items     = 0;
  int cfg_writes     = 0;
  int notes_heard    = 0;
  int ends_heard     = 0;
  int zero_div_heard = 0;

  buzzer_melody_sequencer u_top (.*);

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Duration in ms of a note with tempo t under the current registers
  function automatic int unsigned note_ms(input logic [TEMPO_W-1:0] t, output bit zero_div);
    int unsigned divisor;
    zero_div = 1'b0;
    note_ms = 0;
    if (bpm_mode) begin
      divisor = int'(t) * int'(bpm_cfg);
      if (divisor == 0) zero_div = 1'b1;
      else note_ms = (int'(BPM_NUM) * int'(beat_ref)) / divisor;
    end else begin
      if (t == 0) zero_div = 1'b1;
      else note_ms = int'(OLD_NUM) / int'(t);
    end
  endfunction

  // Apply one beat to the player mirror and return the tone it produces
  function automatic tone_res_t advance_player(note_item_t it);
    tone_res_t   r;
    int unsigned dur;
    bit          zd;
    logic [TEMPO_W-1:0] t;
    r = '0;
    case (it.op)
      OP_LOAD: begin
        note_freq_tab[it.idx]  = it.freq;
        note_tempo_tab[it.idx] = it.tempo;
      end
      OP_START: begin
        play_pos   = '0;
        ticks_left = 0;
        player_on  = 1'b1;
      end
      OP_TICK: begin
        if (player_on) begin
          if (play_pos >= song_len) begin
            r.stop    = 1'b1;
            player_on = 1'b0;
          end else begin
            if (ticks_left > CD_FLOOR) ticks_left--;
            if (ticks_left <= 0) begin
              t = '0;
              if (play_pos < NOTES_DEF) begin
                r.freq = note_freq_tab[play_pos[IDX_W-1:0]];
                t      = note_tempo_tab[play_pos[IDX_W-1:0]];
              end
              dur        = note_ms(t, zd);
              r.start    = 1'b1;
              r.ms       = dur[MS_W-1:0];
              r.err      = zd;
              play_pos   = play_pos + POS_W'(1);
              ticks_left = int'(dur * RELOAD_NUM / RELOAD_DEN);
            end
          end
        end
      end
      default: ;
    endcase
    r.playing = player_on;
    return r;
  endfunction

  // Pick a tempo whose reload stays short; a rare long note in short melodies
  function automatic logic [TEMPO_W-1:0] pick_tempo(int unsigned max_reload);
    logic [TEMPO_W-1:0] t;
    int unsigned        reload;
    bit                 zd;
    int                 i;
    if ($urandom_range(11) == 0) return '0;
    for (i = 0; i < 24; i++) begin
      t = TEMPO_W'($urandom_range(255));
      reload = note_ms(t, zd) * RELOAD_NUM / RELOAD_DEN;
      if (reload <= max_reload) return t;
      if (song_len <= 16 && reload <= 120 && $urandom_range(29) == 0) return t;
    end
    return '0;
  endfunction

  function automatic script_row_t mk_cfg(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic script_row_t mk_beat(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                          logic [FREQ_W-1:0] freq,
                                          logic [TEMPO_W-1:0] tempo);
    script_row_t row;
    row = '{default: '0};
    row.beat = '{op: op, idx: idx, freq: freq, tempo: tempo};
    return row;
  endfunction

  function automatic script_row_t mk_tone(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                          logic [FREQ_W-1:0] freq,
                                          logic [TEMPO_W-1:0] tempo, bit start, bit stop,
                                          logic [FREQ_W-1:0] tfreq, logic [MS_W-1:0] ms,
                                          bit playing, bit err);
    script_row_t row;
    row = mk_beat(op, idx, freq, tempo);
    row.typed = 1'b1;
    row.tone  = '{start: start, stop: stop, freq: tfreq, ms: ms, playing: playing, err: err};
    return row;
  endfunction

  // Directed script
  initial begin
    // idle player: a tick and the unused opcode change nothing
    script.push_back(mk_tone(OP_TICK, 8'h00, 16'h0000, 8'h00, 0, 0, 16'h0000, 0, 0, 0));
    script.push_back(mk_tone(OP_NOP,  8'hFF, 16'hFFFF, 8'hFF, 0, 0, 16'h0000, 0, 0, 0));
    // empty melody ends on the first tick
    script.push_back(mk_tone(OP_START, 8'h00, 16'h0000, 8'h00, 0, 0, 16'h0000, 0, 1, 0));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 0, 1, 16'h0000, 0, 0, 0));
    // note table: zero tempo, field extremes, top slot
    script.push_back(mk_tone(OP_LOAD, 8'h00, 16'hFFFF, 8'h00, 0, 0, 16'h0000, 0, 0, 0));
    script.push_back(mk_tone(OP_LOAD, 8'h01, 16'h0000, 8'hFF, 0, 0, 16'h0000, 0, 0, 0));
    script.push_back(mk_tone(OP_LOAD, 8'h02, 16'h5A5A, 8'h01, 0, 0, 16'h0000, 0, 0, 0));
    script.push_back(mk_tone(OP_LOAD, 8'hFF, 16'hA5A5, 8'h5A, 0, 0, 16'h0000, 0, 0, 0));
    // divide mode: zero tempo error, shortest and longest notes
    script.push_back(mk_cfg(CFG_MEL_LEN, 10'd3));
    script.push_back(mk_tone(OP_START, 8'h00, 16'h0000, 8'h00, 0, 0, 16'h0000, 0, 1, 0));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'hFFFF, 0, 1, 1));
    script.push_back(mk_beat(OP_TICK,  8'h00, 16'h0000, 8'h00));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'h5A5A, 1000, 1, 0));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 0, 1, 16'h0000, 0, 0, 0));
    // bpm mode with zero scale: every divisor is zero
    script.push_back(mk_cfg(CFG_TEMPO_MODE, 10'd1));
    script.push_back(mk_cfg(CFG_BPM_SCALED, 10'd0));
    script.push_back(mk_cfg(CFG_MEL_LEN, 10'd2));
    script.push_back(mk_tone(OP_START, 8'h00, 16'h0000, 8'h00, 0, 0, 16'h0000, 0, 1, 0));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'hFFFF, 0, 1, 1));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'h0000, 0, 1, 1));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 0, 1, 16'h0000, 0, 0, 0));
    // zero beat reference: zero duration without error
    script.push_back(mk_cfg(CFG_BPM_SCALED, 10'd1023));
    script.push_back(mk_cfg(CFG_BEAT_REF, 10'd0));
    script.push_back(mk_tone(OP_START, 8'h00, 16'h0000, 8'h00, 0, 0, 16'h0000, 0, 1, 0));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'hFFFF, 0, 1, 1));
    script.push_back(mk_beat(OP_TICK,  8'h00, 16'h0000, 8'h00));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 0, 1, 16'h0000, 0, 0, 0));
    // longest bpm note: 60000 * 15 / (1 * 1)
    script.push_back(mk_cfg(CFG_BPM_SCALED, 10'd1));
    script.push_back(mk_cfg(CFG_BEAT_REF, 10'd15));
    script.push_back(mk_cfg(CFG_MEL_LEN, 10'd3));
    script.push_back(mk_tone(OP_LOAD,  8'h01, 16'h0000, 8'h00, 0, 0, 16'h0000, 0, 0, 0));
    script.push_back(mk_tone(OP_START, 8'h00, 16'h0000, 8'h00, 0, 0, 16'h0000, 0, 1, 0));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'hFFFF, 0, 1, 1));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'h0000, 0, 1, 1));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 1, 0, 16'h5A5A, 900000, 1, 0));
    script.push_back(mk_tone(OP_TICK,  8'h00, 16'h0000, 8'h00, 0, 1, 16'h0000, 0, 0, 0));
  end

  // Predict the beat, then hold it on the input channel until accepted
  task automatic send_beat(note_item_t it, bit typed = 1'b0, tone_res_t tone = '0);
    tone_res_t want;
    if (!(it.op == OP_NOP || (it.op == OP_TICK && !player_on))) busy_items++;
    want = advance_player(it);
    tones_due.push_back(typed ? tone : want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= it.op;
    note_index_i <= it.idx;
    note_freq_i  <= it.freq;
    note_tempo_i <= it.tempo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and wait until every tone is back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (tones_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TEMPO_MODE: bpm_mode = val[0];
      CFG_BPM_SCALED: bpm_cfg  = val[BPM_W-1:0];
      CFG_BEAT_REF:   beat_ref = val[REF_W-1:0];
      CFG_MEL_LEN:    song_len = val[POS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  // Random melodies: configure, load every note, start, then tick with some noise
  task automatic run_melodies(output int phases);
    int          i;
    int unsigned r;
    int unsigned max_reload;
    logic [CFG_DATA_W-1:0] bpm_val;
    logic [CFG_DATA_W-1:0] ref_val;
    logic [CFG_DATA_W-1:0] len_val;
    note_item_t  it;
    phases = 0;
    while (busy_items < RAND_ITEMS) begin
      settle();
      case (phases % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      case ($urandom_range(7))
        0: bpm_val = 10'd0;
        1: bpm_val = 10'd1023;
        2: bpm_val = CFG_DATA_W'($urandom_range(1023));
        default: bpm_val = CFG_DATA_W'($urandom_range(1023, 200));
      endcase
      ref_val = ($urandom_range(9) == 0) ? 10'd0 : 10'($urandom_range(15, 1));
      if (phases == 0) len_val = 10'd256;
      else if ($urandom_range(9) == 0) len_val = 10'd0;
      else len_val = CFG_DATA_W'($urandom_range(12, 1));
      write_cfg(CFG_TEMPO_MODE, 10'($urandom_range(1)));
      write_cfg(CFG_BPM_SCALED, bpm_val);
      write_cfg(CFG_BEAT_REF, ref_val);
      write_cfg(CFG_MEL_LEN, len_val);
      // the full table plays with the shortest notes
      max_reload = (phases == 0) ? 1 : 8;

      // load the melody
      for (i = 0; i < song_len; i++) begin
        it = '{op: OP_LOAD, idx: i[IDX_W-1:0], freq: FREQ_W'($urandom_range(65535)),
               tempo: pick_tempo(max_reload)};
        send_beat(it);
      end
      it = '{op: OP_START, idx: IDX_W'($urandom_range(255)),
             freq: FREQ_W'($urandom_range(65535)), tempo: TEMPO_W'($urandom_range(255))};
      send_beat(it);

      // play it out with stray loads, restarts and unused opcodes mixed in
      while (busy_items < RAND_ITEMS) begin
        r = $urandom_range(99);
        it = '{op: OP_TICK, idx: IDX_W'($urandom_range(255)),
               freq: FREQ_W'($urandom_range(65535)), tempo: TEMPO_W'($urandom_range(255))};
        if (r < 3) begin
          it.op    = OP_LOAD;
          it.tempo = pick_tempo(max_reload);
        end else if (r < 5) begin
          it.op = OP_NOP;
        end else if (r < 7 && song_len <= 16) begin
          it.op = OP_START;
        end
        send_beat(it);
        if (!player_on) break;
      end

      // ticks after the end are ignored by the player
      repeat ($urandom_range(2)) begin
        it = '{op: OP_TICK, idx: IDX_W'($urandom_range(255)),
               freq: FREQ_W'($urandom_range(65535)), tempo: TEMPO_W'($urandom_range(255))};
        send_beat(it);
      end
      phases++;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Output side: random stall, compare each accepted beat with the oldest tone due
  always @(posedge clk_i) begin
    tone_res_t got;
    tone_res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {tone_start_o, tone_stop_o, tone_freq_o, tone_ms_o, playing_o, div_error_o};
        notes_heard    += int'(got.start);
        ends_heard     += int'(got.stop);
        zero_div_heard += int'(got.err);
        if (tones_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing due: %p", $time, got);
        end else begin
          want = tones_due.pop_front();
          check_field("tone_start", 32'(want.start),   32'(got.start));
          check_field("tone_stop",  32'(want.stop),    32'(got.stop));
          check_field("tone_freq",  32'(want.freq),    32'(got.freq));
          check_field("tone_ms",    32'(want.ms),      32'(got.ms));
          check_field("playing",    32'(want.playing), 32'(got.playing));
          check_field("div_error",  32'(want.err),     32'(got.err));
        end
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Main sequence
  initial begin
    int phases;
    int directed_items;
    int i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed script
    for (i = 0; i < script.size(); i++) begin
      if (script[i].is_cfg) begin
        settle();
        write_cfg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_beat(script[i].beat, script[i].typed, script[i].tone);
      end
    end
    directed_items = items_sent;
    busy_items = 0;

    run_melodies(phases);
    settle();

    $display("Sent %0d beats (%0d scripted) over %0d random melodies, %0d register writes",
             items_sent, directed_items, phases, cfg_writes);
    $display("Heard %0d notes begin, %0d melody ends, %0d zero-divisor notes",
             notes_heard, ends_heard, zero_div_heard);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("Timeout with %0d results still due", tones_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
hdl/bms_pkg.sv
hdl/buzzer_melody_sequencer.sv
bench/tb.sv
